### hdl/utf8_to_utf16_transcoder_top_assert.svh
// Assertion macros shared by the checker of the transcoder.
`ifndef UTF8_TO_UTF16_TRANSCODER_TOP_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define U2U_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("transcoder assertion failed");

// Next-cycle implication, switched off while reset is held.
`define U2U_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("transcoder assertion failed");

// Next-cycle implication that also checks the cycles in reset.
`define U2U_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("transcoder assertion failed");

`endif

### hdl/u2u_pkg.sv
package u2u_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] HIGH_START      = 16'hD800;
    localparam logic [15:0] LOW_START       = 16'hDC00;
    localparam logic [15:0] HALF_BASE_UNITS = 16'h0040;
    // Subtracting 10000 before the shift by ten is the same as subtracting 40 after it.
    localparam logic [15:0] HIGH_OFFSET     = HIGH_START - HALF_BASE_UNITS;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } u2u_unit_t;

    typedef struct packed {
        logic [1:0] count;
        u2u_unit_t  first;
        u2u_unit_t  second;
    } u2u_push_t;

    function automatic logic [2:0] lead_count(input logic [7:0] b);
        logic [2:0] n;
        if (b inside {[8'h00:8'hBF]}) begin
            n = 3'd0;
        end else if (b inside {[8'hC0:8'hDF]}) begin
            n = 3'd1;
        end else if (b inside {[8'hE0:8'hEF]}) begin
            n = 3'd2;
        end else if (b inside {[8'hF0:8'hF7]}) begin
            n = 3'd3;
        end else if (b inside {[8'hF8:8'hFB]}) begin
            n = 3'd4;
        end else begin
            n = 3'd5;
        end
        return n;
    endfunction

    function automatic logic [7:0] lead_mask(input logic [2:0] n);
        logic [7:0] m;
        case (n)
            3'd0: m = 8'h7F;
            3'd1: m = 8'h1F;
            3'd2: m = 8'h0F;
            3'd3: m = 8'h07;
            3'd4: m = 8'h03;
            3'd5: m = 8'h01;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

### hdl/u2u_decode.sv
module u2u_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_byte_in,
    input  logic                room,
    output u2u_pkg::u2u_push_t  push
);

    logic        st_valid_reg;
    logic [7:0]  byte_reg;
    logic [2:0]  pending_reg;
    logic [2:0]  pending_next;
    logic [30:0] acc_reg;
    logic [30:0] acc_next;
    logic [2:0]  lead;
    logic        fire;

    // The held byte is decoded in the cycle the queue can take two units.
    assign fire    = st_valid_reg && room;
    assign s_ready = !st_valid_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 3'd0;
            acc_reg     <= 31'd0;
        end else if (fire) begin
            pending_reg <= pending_next;
            acc_reg     <= acc_next;
        end
    end

    always_comb begin
        lead         = u2u_pkg::lead_count(byte_reg);
        pending_next = 3'd0;
        acc_next     = 31'd0;
        push         = '0;
        if (byte_reg == 8'h00) begin
            push.count            = 2'd1;
            push.first.code_unit  = 16'h0000;
            push.first.last_unit  = 1'b1;
        end else begin
            if (pending_reg == 3'd0) begin
                pending_next = lead;
                acc_next     = 31'(byte_reg & u2u_pkg::lead_mask(lead));
            end else begin
                pending_next = pending_reg - 3'd1;
                acc_next     = {acc_reg[24:0], byte_reg[5:0]};
            end
            if (pending_next != 3'd0) begin
                push.count = 2'd0;
            end else if (|acc_next[30:16]) begin
                push.count            = 2'd2;
                push.first.code_unit  = acc_next[25:10] + u2u_pkg::HIGH_OFFSET;
                push.first.last_unit  = 1'b0;
                push.second.code_unit = u2u_pkg::LOW_START | 16'(acc_next[9:0]);
                push.second.last_unit = 1'b1;
            end else begin
                push.count           = 2'd1;
                push.first.code_unit = acc_next[15:0];
                push.first.last_unit = 1'b1;
            end
        end
        if (!fire) begin
            push.count = 2'd0;
        end
    end

endmodule

### hdl/u2u_queue.sv
module u2u_queue #(
    parameter int DEPTH = u2u_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  u2u_pkg::u2u_push_t  push,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_code_unit,
    output logic                m_last_unit
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    u2u_pkg::u2u_unit_t mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    assign pop         = m_valid && m_ready;
    assign m_valid     = count_reg != '0;
    assign m_code_unit = mem[rd_ptr_reg].code_unit;
    assign m_last_unit = mem[rd_ptr_reg].last_unit;
    // Room for a surrogate pair is needed before any byte is decoded.
    assign room        = count_reg <= CNT_W'(DEPTH - 2);
    assign count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.count);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

### hdl/utf8_to_utf16_transcoder_top.sv
// UTF-8 to UTF-16 transcoder. One byte is taken per cycle while s_ready is high into an input
// register and decoded there against the pending count and code-point accumulator once the
// queue has room for two units; the resulting units go into a small output queue (QUEUE_DEPTH
// entries, a power of two of at least two), so the first unit of a byte is held in the input
// register and then the queue before it is offered. Bytes completing a code point up to FFFF,
// and zero bytes, give one unit; code points above FFFF give a surrogate pair. While units are
// taken the rate is one byte per cycle, but pairs are paced by the output at one unit per cycle.
module utf8_to_utf16_transcoder_top #(
    parameter int QUEUE_DEPTH = u2u_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_last_unit
);

    u2u_pkg::u2u_push_t push;
    logic               room;

    u2u_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_byte_in (s_byte_in),
        .room      (room),
        .push      (push)
    );

    u2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .room        (room),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code_unit (m_code_unit),
        .m_last_unit (m_last_unit)
    );

endmodule

### hdl/u2u_checker.sv
`include "utf8_to_utf16_transcoder_top_assert.svh"

module u2u_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_byte_in,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_code_unit,
    input logic        m_last_unit
);

    // An offered byte waits with its payload unchanged until its transfer.
    `U2U_ASSERT_NEXT(a_in_hold, s_valid && !s_ready, s_valid && $stable(s_byte_in))
    // A stalled result holds its payload.
    `U2U_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
                     m_valid && $stable(m_code_unit) && $stable(m_last_unit))
    // A high surrogate is always followed at once by its low surrogate.
    `U2U_ASSERT_NEXT(a_pair_follows, m_valid && m_ready && !m_last_unit,
                     m_valid && m_last_unit && m_code_unit[15:10] == 6'b110111)
    // The input only stalls while results are waiting to be taken.
    `U2U_ASSERT_NOW(a_stall_backed, !s_ready, m_valid)
    // Reset empties the block.
    `U2U_ASSERT_NEXT_ALWAYS(a_reset_empty, !aresetn, !m_valid && s_ready)

endmodule

bind utf8_to_utf16_transcoder_top u2u_checker u_checker (.*);

### tb/sv/tb_utf8_to_utf16_transcoder_top.sv
module tb_utf8_to_utf16_transcoder_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_BYTES  = 1950;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          LONG_HOLD     = 150;
    localparam logic [7:0]  END_OF_STRING = 8'h00;
    localparam logic [7:0]  CONT_TAG      = 8'h80;
    localparam logic [15:0] TERMINATOR    = 16'h0000;
    localparam logic [31:0] BMP_LIMIT     = 32'h0000FFFF;
    localparam logic [31:0] PLANE_BASE    = 32'h00010000;

    class utf16_unit_scoreboard;
        u2u_pkg::u2u_unit_t awaited_units[$];
        logic [2:0]         cont_left;
        logic [30:0]        code_point;
        int                 failures;

        function new();
            cont_left  = 3'd0;
            code_point = 31'd0;
            failures   = 0;
        endfunction

        function logic [2:0] lead_span(input logic [7:0] b);
            if (b < 8'hC0) return 3'd0;
            if (b < 8'hE0) return 3'd1;
            if (b < 8'hF0) return 3'd2;
            if (b < 8'hF8) return 3'd3;
            if (b < 8'hFC) return 3'd4;
            return 3'd5;
        endfunction

        function void await_unit(input logic [15:0] unit, input logic last);
            u2u_pkg::u2u_unit_t u;
            u.code_unit = unit;
            u.last_unit = last;
            awaited_units.push_back(u);
        endfunction

        function void note_byte(input logic [7:0] b);
            logic [7:0]  keep;
            logic [31:0] offset;
            if (b == END_OF_STRING) begin
                cont_left  = 3'd0;
                code_point = 31'd0;
                await_unit(TERMINATOR, 1'b1);
                return;
            end
            if (cont_left == 3'd0) begin
                cont_left  = lead_span(b);
                // A lead byte keeps seven bits when it starts nothing, otherwise fewer.
                keep       = (cont_left == 3'd0) ? 8'h7F : (8'h3F >> cont_left);
                code_point = {23'd0, b & keep};
            end else begin
                code_point = {code_point[24:0], b[5:0]};
                cont_left  = cont_left - 3'd1;
            end
            if (cont_left != 3'd0) return;
            if ({1'b0, code_point} <= BMP_LIMIT) begin
                await_unit(code_point[15:0], 1'b1);
            end else begin
                // Above 10FFFF the high half simply wraps at sixteen bits.
                offset = {1'b0, code_point} - PLANE_BASE;
                await_unit(offset[25:10] + u2u_pkg::HIGH_START, 1'b0);
                await_unit({6'd0, offset[9:0]} + u2u_pkg::LOW_START, 1'b1);
            end
        endfunction

        function void check_unit(input logic [15:0] unit, input logic last);
            u2u_pkg::u2u_unit_t exp_unit;
            if (awaited_units.size() == 0) begin
                $display("%0t: unit with nothing awaited: expected none, actual %h last %b",
                         $time, unit, last);
                failures++;
                return;
            end
            exp_unit = awaited_units.pop_front();
            if (exp_unit.code_unit !== unit) begin
                $display("%0t: code_unit mismatch: expected %h, actual %h",
                         $time, exp_unit.code_unit, unit);
                failures++;
            end
            if (exp_unit.last_unit !== last) begin
                $display("%0t: last_unit mismatch: expected %b, actual %b",
                         $time, exp_unit.last_unit, last);
                failures++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_byte_in;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_code_unit;
    logic        m_last_unit;

    utf16_unit_scoreboard unit_board;
    logic [7:0]           utf8_stream[$];
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   bytes_sent;
    int                   hold_at;

    utf8_to_utf16_transcoder_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_byte_in   (s_byte_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code_unit (m_code_unit),
        .m_last_unit (m_last_unit)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

    // Appends one sequence: a lead byte for the given span followed by its continuations,
    // cut short when trimmed is non-zero.
    task automatic add_sequence(input int span, input int trimmed);
        logic [7:0] lead;
        int         k;
        case (span)
            0: lead = 8'($urandom_range(8'h7F, 8'h01));
            1: lead = 8'hC0 | 8'($urandom_range(8'h1F));
            2: lead = 8'hE0 | 8'($urandom_range(8'h0F));
            3: lead = 8'hF0 | 8'($urandom_range(8'h07));
            4: lead = 8'hF8 | 8'($urandom_range(8'h03));
            default: lead = 8'hFC | 8'($urandom_range(8'h03));
        endcase
        utf8_stream.push_back(lead);
        for (k = 0; k < span - trimmed; k++) begin
            // Continuations are not checked, so now and then a foreign byte stands in for one.
            if ($urandom_range(19) == 0)
                utf8_stream.push_back(8'($urandom_range(8'hFF, 8'h01)));
            else
                utf8_stream.push_back(CONT_TAG | 8'($urandom_range(8'h3F)));
        end
    endtask

    task automatic build_stream();
        int pick;
        int span;
        utf8_stream = {8'h00, 8'h7F, 8'hBF, 8'hC0, 8'h80, 8'hE2, 8'h82, 8'hAC,
                       8'hF0, 8'h90, 8'h80, 8'h80, 8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
                       8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hE2, 8'h00};
        while (utf8_stream.size() < RANDOM_BYTES + 25) begin
            pick = $urandom_range(99);
            span = $urandom_range(9);
            span = (span > 5) ? span - 4 : span;
            if (pick < 75) begin
                add_sequence(span, 0);
            end else if (pick < 85) begin
                span = (span == 0) ? 1 : span;
                add_sequence(span, $urandom_range(span, 1));
                if ($urandom_range(1) == 0) utf8_stream.push_back(END_OF_STRING);
            end else if (pick < 95) begin
                utf8_stream.push_back(8'($urandom_range(8'hFF)));
            end else begin
                utf8_stream.push_back(END_OF_STRING);
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        unit_board.note_byte(b);
        bytes_sent++;
    endtask

    task automatic take_units();
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) unit_board.check_unit(m_code_unit, m_last_unit);
            if (!hold_done && bytes_sent >= hold_at) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    endtask

    initial begin
        int n;
        int total;
        unit_board    = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        bytes_sent    = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_byte_in <= 8'h00;
        m_ready   <= 1'b0;
        build_stream();
        total   = utf8_stream.size();
        hold_at = (total * 3) / 4;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            take_units();
        join_none
        for (n = 0; n < total; n++) begin
            if (n < total / 3) begin
                send_idle_pct = 19;
                recv_idle_pct = 46;
            end else if (n < (2 * total) / 3) begin
                send_idle_pct = 46;
                recv_idle_pct = 19;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_byte(utf8_stream[n]);
        end
        s_valid <= 1'b0;
        while (unit_board.awaited_units.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (unit_board.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
